@@ design/multi_mode_pseudocolor_map_defines.svh @@
// Assertion macros used by the pseudocolor map top level.
`ifndef MULTI_MODE_PSEUDOCOLOR_MAP_DEFINES_SVH
`define MULTI_MODE_PSEUDOCOLOR_MAP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define MMPM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define MMPM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mmpm_pkg.sv @@
// Package with widths, codes and types of the pseudocolor map.
package mmpm_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int CHAN_W     = 8;
  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int MAP_W      = 3;
  localparam int NUM_W      = 40;
  localparam int MOD_STAGES = 32;
  localparam int DIV_STAGES = 8;
  localparam int LANES      = 3;

  localparam logic [REG_IDX_W-1:0] REG_MAP_SELECT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_LOW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_HIGH = 2'd2;

  localparam logic [MAP_W-1:0] MAP_SPLIT  = 3'd0;
  localparam logic [MAP_W-1:0] MAP_HOT    = 3'd1;
  localparam logic [MAP_W-1:0] MAP_COLD   = 3'd2;
  localparam logic [MAP_W-1:0] MAP_JET    = 3'd3;
  localparam logic [MAP_W-1:0] MAP_CYCLIC = 3'd4;
  localparam logic [MAP_W-1:0] MAP_GRAY   = 3'd5;
  localparam logic [MAP_W-1:0] MAP_BLUE   = 3'd6;

  localparam logic signed [SAMPLE_W-1:0] RANGE_LOW_RST  = 32'sh0000_0000;
  localparam logic signed [SAMPLE_W-1:0] RANGE_HIGH_RST = 32'sh0001_0000;

  localparam logic [CHAN_W-1:0] K_FULL      = 8'd255;
  localparam logic [CHAN_W-1:0] K_JET_LOW   = 8'd111;
  localparam logic [CHAN_W-1:0] K_SPLIT_RED = 8'd63;
  localparam logic [CHAN_W-1:0] JET_BASE    = 8'd144;
  localparam logic [CHAN_W-1:0] SPLIT_BASE  = 8'd192;

  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_FULL,
    SRC_Q0,
    SRC_INV_Q0,
    SRC_Q0_JET,
    SRC_Q0_SPLIT,
    SRC_Q1,
    SRC_Q2,
    SRC_CEIL0,
    SRC_INV_CEIL0
  } chan_src_t;

  typedef struct packed {
    logic      err;
    chan_src_t red;
    chan_src_t green;
    chan_src_t blue;
  } tag_t;

endpackage

@@ design/mmpm_sample_if.sv @@
// Stream interface carrying one signed Q16.16 sample per beat.
interface mmpm_sample_if;
  import mmpm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

@@ design/mmpm_color_if.sv @@
// Stream interface carrying one RGB color and error flag per beat.
interface mmpm_color_if;
  import mmpm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              range_error;

  modport source (output valid, output red, output green, output blue,
                  output range_error, input ready);
  modport sink (input valid, input red, input green, input blue,
                input range_error, output ready);
endinterface

@@ design/multi_mode_pseudocolor_map.sv @@
// Top level: pipelined multi-mode pseudocolor map from Q16.16 sample to RGB.
//
//   channel   dir  payload                          beat
//   samples   in   sample (s32 Q16.16)              valid & ready
//   colors    out  red, green, blue, range_error    valid & ready
//   cfg_*     in   cfg_index, cfg_wdata             cfg_wr_en
//
// One sample per clock while no color beat waits; a sample passes through the
// modulo pipe, stages P1 to P4, the quotient pipe and the output register.
// Reset clears valid bits and restores the configuration registers to their reset values.
// A waiting color beat holds every stage; ready stays high while the
// output register is empty or being taken.
`include "multi_mode_pseudocolor_map_defines.svh"

module multi_mode_pseudocolor_map (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [mmpm_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [mmpm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  mmpm_sample_if.sink                         samples,
  mmpm_color_if.source                        colors
);
  import mmpm_pkg::*;

  function automatic logic [31:0] mod_step(input logic [31:0] rem, input logic din,
                                           input logic [31:0] den);
    logic [32:0] sh;
    sh = {rem, din};
    if (sh >= {1'b0, den}) begin
      sh = sh - {1'b0, den};
    end
    return sh[31:0];
  endfunction

  function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] rem,
                                              input logic [NUM_W-1:0] dsh);
    if (rem >= dsh) begin
      return {1'b1, rem - dsh};
    end
    return {1'b0, rem};
  endfunction

  function automatic logic [CHAN_W-1:0] chan_pick(input chan_src_t src,
                                                  input logic [CHAN_W-1:0] q0,
                                                  input logic [CHAN_W-1:0] q1,
                                                  input logic [CHAN_W-1:0] q2,
                                                  input logic nz0);
    logic [CHAN_W-1:0] res;
    unique case (src)
      SRC_ZERO:      res = '0;
      SRC_FULL:      res = K_FULL;
      SRC_Q0:        res = q0;
      SRC_INV_Q0:    res = K_FULL - q0;
      SRC_Q0_JET:    res = q0 + JET_BASE;
      SRC_Q0_SPLIT:  res = q0 + SPLIT_BASE;
      SRC_Q1:        res = q1;
      SRC_Q2:        res = q2;
      SRC_CEIL0:     res = q0 + CHAN_W'(nz0);
      SRC_INV_CEIL0: res = K_FULL - q0 - CHAN_W'(nz0);
      default:       res = '0;
    endcase
    return res;
  endfunction

  logic [MAP_W-1:0]           map_sel;
  logic signed [SAMPLE_W-1:0] range_low;
  logic signed [SAMPLE_W-1:0] range_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_sel    <= MAP_SPLIT;
      range_low  <= RANGE_LOW_RST;
      range_high <= RANGE_HIGH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAP_SELECT: map_sel    <= cfg_wdata[MAP_W-1:0];
        REG_RANGE_LOW:  range_low  <= cfg_wdata;
        REG_RANGE_HIGH: range_high <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic signed [32:0] d_full;
  logic [31:0]        den_d;
  logic               cfg_err;
  logic [MAP_W-1:0]   map_eff;
  logic [33:0]        dd1, dd2, dd3;

  assign d_full  = 33'(range_high) - 33'(range_low);
  assign den_d   = d_full[31:0];
  assign cfg_err = (d_full <= 33'sd0);
  assign map_eff = (map_sel > MAP_BLUE) ? MAP_SPLIT : map_sel;
  assign dd1     = 34'(den_d);
  assign dd2     = 34'({den_d, 1'b0});
  assign dd3     = dd1 + dd2;

  logic adv;
  logic out_vld;
  assign adv           = !out_vld || colors.ready;
  assign samples.ready = adv;

  // modulo pipe
  logic signed [32:0] v_in, v_in_neg;
  logic [31:0]        a_in;
  assign v_in     = 33'(samples.sample) - 33'(range_low);
  assign v_in_neg = -v_in;
  assign a_in     = v_in[32] ? v_in_neg[31:0] : v_in[31:0];

  logic                       mod_vld [0:MOD_STAGES];
  logic signed [SAMPLE_W-1:0] mod_s   [0:MOD_STAGES];
  logic [31:0]                mod_a   [0:MOD_STAGES];
  logic [31:0]                mod_rem [0:MOD_STAGES];
  logic                       mod_neg [0:MOD_STAGES];

  always_ff @(posedge clk) begin
    if (adv) begin
      mod_s[0]   <= samples.sample;
      mod_a[0]   <= a_in;
      mod_rem[0] <= '0;
      mod_neg[0] <= v_in[32];
      for (int k = 1; k <= MOD_STAGES; k++) begin
        mod_s[k]   <= mod_s[k-1];
        mod_a[k]   <= mod_a[k-1] << 1;
        mod_rem[k] <= mod_step(mod_rem[k-1], mod_a[k-1][31], den_d);
        mod_neg[k] <= mod_neg[k-1];
      end
    end
  end

  // P1: offset and wrapped position
  logic signed [32:0] v1;
  logic [31:0]        w1, x1;
  logic               p1_vld;
  logic signed [SAMPLE_W-1:0] p1_s;
  logic signed [32:0] p1_v;
  logic [31:0]        p1_x;

  always_comb begin
    v1 = 33'(mod_s[MOD_STAGES]) - 33'(range_low);
    w1 = (mod_neg[MOD_STAGES] && mod_rem[MOD_STAGES] != '0) ?
         den_d - mod_rem[MOD_STAGES] : mod_rem[MOD_STAGES];
    x1 = (map_eff == MAP_CYCLIC) ? w1 : v1[31:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_s <= mod_s[MOD_STAGES];
      p1_v <= v1;
      p1_x <= x1;
    end
  end

  // P2: scaled position
  logic [33:0]                t2;
  logic                       p2_vld;
  logic signed [SAMPLE_W-1:0] p2_s;
  logic signed [32:0]         p2_v;
  logic [33:0]                p2_t;

  always_comb begin
    unique case (map_eff)
      MAP_HOT, MAP_COLD, MAP_CYCLIC: t2 = 34'(p1_x) + 34'({p1_x, 1'b0});
      MAP_JET:                       t2 = 34'({p1_x, 2'b00});
      default:                       t2 = 34'(p1_x);
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_s <= p1_s;
      p2_v <= p1_v;
      p2_t <= t2;
    end
  end

  // P3: segment and split-map flags
  logic [1:0]         seg3;
  logic signed [32:0] s2;
  logic signed [33:0] u2, l34;
  logic               p3_vld;
  logic signed [SAMPLE_W-1:0] p3_s;
  logic signed [32:0] p3_v;
  logic [33:0]        p3_t;
  logic [1:0]         p3_seg;
  logic               p3_below, p3_above, p3_spos, p3_hibad, p3_s2gt, p3_loneg, p3_u2gt;

  always_comb begin
    if (p2_t >= dd3) begin
      seg3 = 2'd3;
    end else if (p2_t >= dd2) begin
      seg3 = 2'd2;
    end else if (p2_t >= dd1) begin
      seg3 = 2'd1;
    end else begin
      seg3 = 2'd0;
    end
    s2  = {p2_s, 1'b0};
    u2  = {p2_v, 1'b0};
    l34 = 34'sd0 - 34'(range_low);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_s     <= p2_s;
      p3_v     <= p2_v;
      p3_t     <= p2_t;
      p3_seg   <= seg3;
      p3_below <= (p2_v < 33'sd0);
      p3_above <= (p2_v >= d_full);
      p3_spos  <= (p2_s > 32'sd0);
      p3_hibad <= (range_high <= 32'sd0) || (p2_s > range_high);
      p3_s2gt  <= (s2 > 33'(range_high));
      p3_loneg <= (range_low < 32'sd0);
      p3_u2gt  <= (u2 > l34);
    end
  end

  // P4: numerators, denominator and channel sources
  logic [33:0] segd, ynorm;
  logic [32:0] y2pos, y2neg, nl;
  logic [31:0] hpos, lneg;
  logic [31:0] y0_4, y1_4, y2_4, den4;
  logic [CHAN_W-1:0] k0_4;
  tag_t        tag4;
  chan_src_t   sx, sy, sz;

  logic        p4_vld;
  logic [31:0] p4_y0, p4_y1, p4_y2, p4_den;
  logic [CHAN_W-1:0] p4_k0;
  tag_t        p4_tag;

  always_comb begin
    unique case (p3_seg)
      2'd0: segd = '0;
      2'd1: segd = dd1;
      2'd2: segd = dd2;
      2'd3: segd = dd3;
      default: segd = '0;
    endcase
    ynorm = p3_t - segd;
    hpos  = range_high[31:0];
    nl    = 33'd0 - 33'(range_low);
    lneg  = nl[31:0];
    y2pos = {p3_s[31:0], 1'b0} - {1'b0, hpos};
    y2neg = {p3_v[31:0], 1'b0} - {1'b0, lneg};
    y0_4  = ynorm[31:0];
    y1_4  = '0;
    y2_4  = '0;
    den4  = den_d;
    k0_4  = K_FULL;
    sx    = SRC_ZERO;
    sy    = SRC_ZERO;
    sz    = SRC_ZERO;
    tag4  = '{err: 1'b0, red: SRC_ZERO, green: SRC_ZERO, blue: SRC_ZERO};
    if (cfg_err) begin
      tag4.err = 1'b1;
    end else begin
      unique case (map_eff)
        MAP_HOT, MAP_COLD: begin
          if (p3_below) begin
            sx = SRC_ZERO;
          end else if (p3_above) begin
            sx = SRC_FULL;
            sy = SRC_FULL;
            sz = SRC_FULL;
          end else begin
            unique case (p3_seg)
              2'd0: sx = SRC_Q0;
              2'd1: begin
                sx = SRC_FULL;
                sy = SRC_Q0;
              end
              default: begin
                sx = SRC_FULL;
                sy = SRC_FULL;
                sz = SRC_Q0;
              end
            endcase
          end
          tag4.green = sy;
          if (map_eff == MAP_HOT) begin
            tag4.red  = sx;
            tag4.blue = sz;
          end else begin
            tag4.blue = sx;
            tag4.red  = sz;
          end
        end
        MAP_JET: begin
          if (p3_below) begin
            tag4.red = SRC_ZERO;
          end else if (p3_above) begin
            tag4.red = SRC_FULL;
          end else begin
            unique case (p3_seg)
              2'd0: begin
                k0_4      = K_JET_LOW;
                tag4.blue = SRC_Q0_JET;
              end
              2'd1: begin
                tag4.green = SRC_Q0;
                tag4.blue  = SRC_FULL;
              end
              2'd2: begin
                tag4.red   = SRC_Q0;
                tag4.green = SRC_FULL;
                tag4.blue  = SRC_INV_Q0;
              end
              default: begin
                tag4.red   = SRC_FULL;
                tag4.green = SRC_INV_CEIL0;
              end
            endcase
          end
        end
        MAP_CYCLIC: begin
          unique case (p3_seg)
            2'd0: begin
              tag4.red  = SRC_INV_CEIL0;
              tag4.blue = SRC_CEIL0;
            end
            2'd1: begin
              tag4.green = SRC_Q0;
              tag4.blue  = SRC_INV_Q0;
            end
            default: begin
              tag4.red   = SRC_Q0;
              tag4.green = SRC_INV_Q0;
            end
          endcase
        end
        MAP_GRAY: begin
          if (p3_below) begin
            tag4.red = SRC_ZERO;
          end else if (p3_above) begin
            tag4.red   = SRC_FULL;
            tag4.green = SRC_FULL;
            tag4.blue  = SRC_FULL;
          end else begin
            tag4.red   = SRC_Q0;
            tag4.green = SRC_Q0;
            tag4.blue  = SRC_Q0;
          end
        end
        MAP_BLUE: begin
          if (p3_below) begin
            tag4.blue = SRC_ZERO;
          end else if (p3_above) begin
            tag4.blue = SRC_FULL;
          end else begin
            tag4.blue = SRC_Q0;
          end
        end
        default: begin
          if (p3_spos) begin
            if (p3_hibad) begin
              tag4.red   = SRC_FULL;
              tag4.green = SRC_FULL;
              tag4.blue  = SRC_FULL;
            end else begin
              den4       = hpos;
              y0_4       = p3_s[31:0];
              k0_4       = K_SPLIT_RED;
              y1_4       = p3_s[31:0];
              y2_4       = y2pos[31:0];
              tag4.red   = SRC_Q0_SPLIT;
              tag4.green = SRC_Q1;
              tag4.blue  = p3_s2gt ? SRC_Q2 : SRC_ZERO;
            end
          end else if (p3_loneg && !p3_below) begin
            den4       = lneg;
            y1_4       = p3_v[31:0];
            y2_4       = y2neg[31:0];
            tag4.green = SRC_Q1;
            tag4.blue  = p3_u2gt ? SRC_Q2 : SRC_ZERO;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_y0  <= y0_4;
      p4_y1  <= y1_4;
      p4_y2  <= y2_4;
      p4_k0  <= k0_4;
      p4_den <= den4;
      p4_tag <= tag4;
    end
  end

  // quotient pipe: stage 0 takes the scaled numerators
  logic [NUM_W-1:0]  n0, n1, n2;
  logic              dv_vld  [0:DIV_STAGES];
  logic [NUM_W-1:0]  dv_rem  [0:DIV_STAGES][0:LANES-1];
  logic [CHAN_W-1:0] dv_q    [0:DIV_STAGES][0:LANES-1];
  logic [31:0]       dv_den  [0:DIV_STAGES];
  tag_t              dv_tag  [0:DIV_STAGES];
  logic [NUM_W:0]    dv_step [1:DIV_STAGES][0:LANES-1];

  assign n0 = NUM_W'(p4_y0) * NUM_W'(p4_k0);
  assign n1 = {p4_y1, 8'b0} - NUM_W'(p4_y1);
  assign n2 = {p4_y2, 8'b0} - NUM_W'(p4_y2);

  always_comb begin
    for (int i = 1; i <= DIV_STAGES; i++) begin
      for (int j = 0; j < LANES; j++) begin
        dv_step[i][j] = div_step(dv_rem[i-1][j], NUM_W'(dv_den[i-1]) << (DIV_STAGES - i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0][0] <= n0;
      dv_rem[0][1] <= n1;
      dv_rem[0][2] <= n2;
      for (int j = 0; j < LANES; j++) begin
        dv_q[0][j] <= '0;
      end
      dv_den[0] <= p4_den;
      dv_tag[0] <= p4_tag;
      for (int i = 1; i <= DIV_STAGES; i++) begin
        for (int j = 0; j < LANES; j++) begin
          dv_rem[i][j] <= dv_step[i][j][NUM_W-1:0];
          dv_q[i][j]   <= {dv_q[i-1][j][CHAN_W-2:0], dv_step[i][j][NUM_W]};
        end
        dv_den[i] <= dv_den[i-1];
        dv_tag[i] <= dv_tag[i-1];
      end
    end
  end

  // output register
  logic [CHAN_W-1:0] out_red, out_green, out_blue;
  logic              out_err, nz0;
  tag_t              tag_f;

  assign tag_f = dv_tag[DIV_STAGES];
  assign nz0   = (dv_rem[DIV_STAGES][0] != '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red   <= chan_pick(tag_f.red, dv_q[DIV_STAGES][0], dv_q[DIV_STAGES][1],
                             dv_q[DIV_STAGES][2], nz0);
      out_green <= chan_pick(tag_f.green, dv_q[DIV_STAGES][0], dv_q[DIV_STAGES][1],
                             dv_q[DIV_STAGES][2], nz0);
      out_blue  <= chan_pick(tag_f.blue, dv_q[DIV_STAGES][0], dv_q[DIV_STAGES][1],
                             dv_q[DIV_STAGES][2], nz0);
      out_err   <= tag_f.err;
    end
  end

  assign colors.valid       = out_vld;
  assign colors.red         = out_red;
  assign colors.green       = out_green;
  assign colors.blue        = out_blue;
  assign colors.range_error = out_err;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= MOD_STAGES; k++) begin
        mod_vld[k] <= 1'b0;
      end
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
      for (int i = 0; i <= DIV_STAGES; i++) begin
        dv_vld[i] <= 1'b0;
      end
      out_vld <= 1'b0;
    end else if (adv) begin
      mod_vld[0] <= samples.valid;
      for (int k = 1; k <= MOD_STAGES; k++) begin
        mod_vld[k] <= mod_vld[k-1];
      end
      p1_vld    <= mod_vld[MOD_STAGES];
      p2_vld    <= p1_vld;
      p3_vld    <= p2_vld;
      p4_vld    <= p3_vld;
      dv_vld[0] <= p4_vld;
      for (int i = 1; i <= DIV_STAGES; i++) begin
        dv_vld[i] <= dv_vld[i-1];
      end
      out_vld <= dv_vld[DIV_STAGES];
    end
  end

  `MMPM_ASSERT_IMP(a_err_black, clk, rst, colors.valid && colors.range_error, colors.red == '0 && colors.green == '0 && colors.blue == '0, "range error beat is not black")
  `MMPM_ASSERT_IMP(a_gray_equal, clk, rst, colors.valid && !colors.range_error && map_eff == MAP_GRAY, colors.red == colors.green && colors.green == colors.blue, "gray beat has unequal channels")
  `MMPM_ASSERT_IMP(a_cyclic_sum, clk, rst, colors.valid && !colors.range_error && map_eff == MAP_CYCLIC, 9'(colors.red) + 9'(colors.blue) == 9'd255 || 9'(colors.green) + 9'(colors.blue) == 9'd255 || 9'(colors.red) + 9'(colors.green) == 9'd255, "cyclic beat off the color wheel")
  `MMPM_ASSERT_NXT(a_map_write, clk, rst, cfg_wr_en && cfg_index == REG_MAP_SELECT, map_sel == $past(cfg_wdata[MAP_W-1:0]), "map select write lost")

endmodule
